// File: sv/tels_pkg.sv
package tels_pkg;

    localparam int ByteW = 8;

    localparam logic [ByteW-1:0] BYTE_NUL    = 8'h00;
    localparam logic [ByteW-1:0] BYTE_LF     = 8'h0A;
    localparam logic [ByteW-1:0] BYTE_CR     = 8'h0D;
    localparam logic [ByteW-1:0] BYTE_UTF8_0 = 8'hEF;
    localparam logic [ByteW-1:0] BYTE_UTF8_1 = 8'hBB;
    localparam logic [ByteW-1:0] BYTE_UTF8_2 = 8'hBF;
    localparam logic [ByteW-1:0] BYTE_FE     = 8'hFE;
    localparam logic [ByteW-1:0] BYTE_FF     = 8'hFF;

    // line end codes
    localparam logic [1:0] LE_CR   = 2'd0;
    localparam logic [1:0] LE_LF   = 2'd1;
    localparam logic [1:0] LE_CRLF = 2'd2;
    localparam logic [1:0] LE_BAD  = 2'd3;

    // encoding codes
    localparam logic [1:0] ENC_PLAIN = 2'd0;
    localparam logic [1:0] ENC_UTF8  = 2'd1;
    localparam logic [1:0] ENC_UCS2  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SYSTEM_LINE_END    = 2'd0;
    localparam logic [1:0] REG_ENCODED_MODE       = 2'd1;
    localparam logic [1:0] REG_HOST_LITTLE_ENDIAN = 2'd2;

    // head byte counter values while the mark is undecided
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef enum logic [1:0] {
        MK_UNDECIDED = 2'd0,
        MK_PLAIN     = 2'd1,
        MK_UTF8      = 2'd2,
        MK_UCS2      = 2'd3
    } mark_kind_t;

    typedef struct packed {
        logic [1:0] system_line_end;
        logic       encoded_mode;
        logic       host_little_endian;
    } cfg_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] line_end;
        logic       swap_needed;
        logic [1:0] encoding;
    } result_t;

endpackage

// File: sv/tels_cfg_regs.sv
module tels_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [1:0]         cfg_data,
    output tels_pkg::cfg_t     cfg
);

    tels_pkg::cfg_t cfg_reg;
    tels_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                tels_pkg::REG_SYSTEM_LINE_END: begin
                    // out of range code folds onto CRLF
                    cfg_next.system_line_end = (cfg_data == tels_pkg::LE_BAD) ?
                                               tels_pkg::LE_CRLF : cfg_data;
                end
                tels_pkg::REG_ENCODED_MODE: begin
                    cfg_next.encoded_mode = cfg_data[0];
                end
                tels_pkg::REG_HOST_LITTLE_ENDIAN: begin
                    cfg_next.host_little_endian = cfg_data[0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.system_line_end    <= tels_pkg::LE_LF;
            cfg_reg.encoded_mode       <= 1'b0;
            cfg_reg.host_little_endian <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/tels_scan.sv
module tels_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          beat_in,
    input  logic [tels_pkg::ByteW-1:0]    data_byte,
    input  logic                          last_byte,
    input  tels_pkg::cfg_t                cfg,
    output logic                          res_valid,
    output tels_pkg::result_t             res
);

    tels_pkg::mark_kind_t           mark_reg, mark_next;
    logic [1:0]                     count_reg, count_next;
    logic [tels_pkg::ByteW-1:0]     head_reg, head_next;
    logic [tels_pkg::ByteW-1:0]     unit_lo_reg, unit_lo_next;
    logic                           phase_reg, phase_next;
    logic                           cr_reg, cr_next;
    logic                           lf_reg, lf_next;
    logic                           bare_reg, bare_next;
    logic                           rej_reg, rej_next;
    logic                           prev_zero_reg, prev_zero_next;

    logic                           b_zero, b_cr, b_lf, h_zero;
    logic                           ucs_mark, utf_start, little;
    logic [1:0]                     le;

    assign b_zero = (data_byte == tels_pkg::BYTE_NUL);
    assign b_cr   = (data_byte == tels_pkg::BYTE_CR);
    assign b_lf   = (data_byte == tels_pkg::BYTE_LF);
    assign h_zero = (head_reg == tels_pkg::BYTE_NUL);

    assign ucs_mark  = (head_reg == tels_pkg::BYTE_FE && data_byte == tels_pkg::BYTE_FF) ||
                       (head_reg == tels_pkg::BYTE_FF && data_byte == tels_pkg::BYTE_FE);
    assign utf_start = (head_reg == tels_pkg::BYTE_UTF8_0) &&
                       (data_byte == tels_pkg::BYTE_UTF8_1);
    assign little    = (head_reg == tels_pkg::BYTE_FF);

    // state update for one beat
    always_comb begin
        mark_next      = mark_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        unit_lo_next   = unit_lo_reg;
        phase_next     = phase_reg;
        cr_next        = cr_reg;
        lf_next        = lf_reg;
        bare_next      = bare_reg;
        rej_next       = rej_reg;
        prev_zero_next = prev_zero_reg;
        if (beat_in) begin
            case (mark_reg)
                tels_pkg::MK_UNDECIDED: begin
                    case (count_reg)
                        tels_pkg::CNT_NONE: begin
                            head_next  = data_byte;
                            count_next = tels_pkg::CNT_ONE;
                            if (last_byte) begin
                                mark_next      = tels_pkg::MK_PLAIN;
                                bare_next      = b_zero;
                                prev_zero_next = b_zero;
                                cr_next        = b_cr;
                                lf_next        = b_lf;
                            end
                        end
                        tels_pkg::CNT_ONE: begin
                            count_next = tels_pkg::CNT_TWO;
                            if (ucs_mark) begin
                                mark_next = tels_pkg::MK_UCS2;
                            end else if (last_byte || !utf_start) begin
                                // held byte and this one scanned as plain text
                                mark_next      = tels_pkg::MK_PLAIN;
                                bare_next      = h_zero | b_zero;
                                rej_next       = h_zero & b_zero;
                                prev_zero_next = b_zero;
                                cr_next        = (head_reg == tels_pkg::BYTE_CR) | b_cr;
                                lf_next        = (head_reg == tels_pkg::BYTE_LF) | b_lf;
                            end
                        end
                        default: begin
                            count_next = tels_pkg::CNT_TWO;
                            if (data_byte == tels_pkg::BYTE_UTF8_2) begin
                                mark_next = tels_pkg::MK_UTF8;
                            end else begin
                                // EF BB carry no zero, CR or LF
                                mark_next      = tels_pkg::MK_PLAIN;
                                bare_next      = b_zero;
                                prev_zero_next = b_zero;
                                cr_next        = b_cr;
                                lf_next        = b_lf;
                            end
                        end
                    endcase
                end
                tels_pkg::MK_PLAIN: begin
                    if (b_zero) begin
                        rej_next  = rej_reg | prev_zero_reg;
                        bare_next = 1'b1;
                    end
                    prev_zero_next = b_zero;
                    cr_next        = cr_reg | b_cr;
                    lf_next        = lf_reg | b_lf;
                end
                tels_pkg::MK_UTF8: begin
                    cr_next = cr_reg | b_cr;
                    lf_next = lf_reg | b_lf;
                end
                default: begin
                    if (!phase_reg) begin
                        unit_lo_next = data_byte;
                        phase_next   = 1'b1;
                    end else begin
                        phase_next = 1'b0;
                        if (little) begin
                            cr_next = cr_reg | (b_zero && unit_lo_reg == tels_pkg::BYTE_CR);
                            lf_next = lf_reg | (b_zero && unit_lo_reg == tels_pkg::BYTE_LF);
                        end else begin
                            cr_next = cr_reg | (b_cr && unit_lo_reg == tels_pkg::BYTE_NUL);
                            lf_next = lf_reg | (b_lf && unit_lo_reg == tels_pkg::BYTE_NUL);
                        end
                    end
                end
            endcase
        end
    end

    // result from the updated flags
    always_comb begin
        if (!cr_next && !lf_next) begin
            le = cfg.system_line_end;
        end else if (cr_next) begin
            le = lf_next ? tels_pkg::LE_CRLF : tels_pkg::LE_CR;
        end else begin
            le = tels_pkg::LE_LF;
        end

        res = '0;
        if (rej_next) begin
            res.encoding    = tels_pkg::ENC_PLAIN;
            res.swap_needed = 1'b0;
            res.line_end    = cfg.system_line_end;
            res.accepted    = 1'b0;
        end else begin
            case (mark_next)
                tels_pkg::MK_UTF8: res.encoding = tels_pkg::ENC_UTF8;
                tels_pkg::MK_UCS2: res.encoding = tels_pkg::ENC_UCS2;
                default:           res.encoding = tels_pkg::ENC_PLAIN;
            endcase
            res.swap_needed = (mark_next == tels_pkg::MK_UCS2) &&
                              (little != cfg.host_little_endian);
            res.line_end    = le;
            res.accepted    = cfg.encoded_mode ||
                              (!bare_next && le == cfg.system_line_end);
        end
    end

    assign res_valid = beat_in && last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn || res_valid) begin
            mark_reg      <= tels_pkg::MK_UNDECIDED;
            count_reg     <= tels_pkg::CNT_NONE;
            phase_reg     <= 1'b0;
            cr_reg        <= 1'b0;
            lf_reg        <= 1'b0;
            bare_reg      <= 1'b0;
            rej_reg       <= 1'b0;
            prev_zero_reg <= 1'b0;
        end else begin
            mark_reg      <= mark_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            cr_reg        <= cr_next;
            lf_reg        <= lf_next;
            bare_reg      <= bare_next;
            rej_reg       <= rej_next;
            prev_zero_reg <= prev_zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg    <= head_next;
        unit_lo_reg <= unit_lo_next;
    end

endmodule

// File: sv/tels_out_reg.sv
module tels_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tels_pkg::result_t res,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata
);

    logic              valid_reg, valid_next;
    tels_pkg::result_t data_reg;

    // a new result may land in the same cycle the held one is taken
    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = {2'b00, data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

endmodule

// File: sv/text_encoding_line_end_sniffer.sv
// Text head sniffer: finds a UTF-8 or UCS-2 byte order mark, the line end
// style and whether the head looks like text.
// Input channel (s_): one byte of the file head per beat, s_tlast on the
// final byte. Result channel (m_): one beat per head, sent after the final
// byte, carrying encoding, swap flag, line end and the accepted flag.
// Configuration channel (cfg_): register index and data, always ready;
// write only while no head is in progress.
// The result is registered and appears in the cycle after the final input beat.
// Throughput: one byte per cycle while s_tready is high; each byte updates a
// handful of flag registers, and the result lands in a single output register.
// Stall: while the result register is full and m_tready is low, s_tready
// drops; input beats are still taken in the cycle the result is drained.
// Reset (aresetn low, synchronous): detection state and the output valid
// clear, registers return to line end LF, encoded mode off and host
// little endian.
module text_encoding_line_end_sniffer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] encoding, [2] swap_needed, [4:3] line_end,
                                  // [5] accepted, [7:6] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_data
);

    tels_pkg::cfg_t    cfg;
    tels_pkg::result_t res;
    logic              res_valid;
    logic              out_free;
    logic              beat_in;

    assign s_tready = out_free;
    assign beat_in  = s_tvalid && out_free;

    tels_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tels_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_in   (beat_in),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    tels_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
